### design/sfsr_pkg.sv
// ----------------------------------------------------------------------------
// sfsr_pkg
// Types and constants shared by the framed status receiver modules.
// ----------------------------------------------------------------------------
package sfsr_pkg;

  localparam int unsigned ADDR_W       = 6;
  localparam int unsigned BUF_DEPTH    = 64;
  localparam int unsigned STATUS_BYTES = 19;
  localparam int unsigned SUM_FIRST    = 14;
  localparam int unsigned SUM_LAST     = 18;
  localparam int unsigned SETPOINT_POS = 1;
  localparam int unsigned SUM_W        = 11;
  localparam int unsigned CNT_W        = 16;

  localparam logic [7:0]        SYNC_BYTE      = 8'hEB;
  localparam logic [3:0]        ID_MARK        = 4'h9;
  localparam logic [3:0]        ID_STATUS      = 4'h0;
  localparam logic [3:0]        ID_LOG         = 4'h2;
  localparam logic signed [7:0] SETPOINT_RESET = 8'sd35;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_CSUM    = 2'd1,
    EV_ID      = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_POLL = 2'd1,
    REQ_SENT = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_SYNC = 4'b0001,
    PH_ID   = 4'b0010,
    PH_HDR  = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SHOW = 3'b100
  } back_state_t;

  // one queued job: an error result or a payload run
  typedef struct packed {
    event_t             ev;
    logic               kind;
    logic [ADDR_W-1:0]  len;
    logic [SUM_W-1:0]   sum;
    logic               fail;
    logic [CNT_W-1:0]   good;
    logic [CNT_W-1:0]   errs;
  } job_t;

  // payload buffer write port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

### design/sync_framed_status_receiver.sv
// ----------------------------------------------------------------------------
// sync_framed_status_receiver
// Serial frame receiver for status and log report frames.
// ----------------------------------------------------------------------------
// A request or byte is taken whenever the two-entry job queue has room and,
// in the payload phase, no payload run is still being emitted. A good frame
// gives its payload as a run of results, each one a payload buffer read and
// then the output register; an error result goes straight to the output
// register. The payload buffer has a single write and read port, so payload
// bytes of the next frame wait until the previous run has been fully taken.
module sync_framed_status_receiver #(
  parameter int unsigned LOG_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic [1:0]        s_tuser,   // [1:0] req_type
  input  logic              cfg_we,
  input  logic signed [7:0] cfg_wdata, // setpoint_limit
  output logic              m_tvalid,
  input  logic              m_tready,
  // [5:0] byte_index, [13:6] byte_value, [24:14] current_sum,
  // [25] config_fail, [41:26] good_frames, [57:42] error_total, [63:58] zero
  output logic [63:0]       m_tdata,
  output logic [2:0]        m_tuser,   // [1:0] event_res, [2] frame_kind
  output logic              m_tlast
);
  import sfsr_pkg::*;

  buf_wr_t           buf_wr;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  job_t              head_job;
  logic              run_done;
  logic              buf_re;
  logic [ADDR_W-1:0] buf_raddr;
  logic [7:0]        buf_rdata;
  logic [1:0]        event_res;
  logic              frame_kind;
  logic [ADDR_W-1:0] byte_index;
  logic [7:0]        byte_value;
  logic [SUM_W-1:0]  current_sum;
  logic              config_fail;
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  error_total;

  sfsr_front #(
    .LOG_BYTES(LOG_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .req_type (s_tuser),
    .rx_byte  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .buf_wr   (buf_wr),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .run_done (run_done)
  );

  sfsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  sfsr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (buf_wr.we),
    .waddr(buf_wr.addr),
    .wdata(buf_wr.data),
    .re   (buf_re),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  sfsr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .buf_re     (buf_re),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .run_done   (run_done),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .event_res  (event_res),
    .frame_kind (frame_kind),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .last       (m_tlast),
    .current_sum(current_sum),
    .config_fail(config_fail),
    .good_frames(good_frames),
    .error_total(error_total)
  );

  assign m_tdata = {6'd0, error_total, good_frames, config_fail, current_sum,
                    byte_value, byte_index};
  assign m_tuser = {frame_kind, event_res};

endmodule

### design/sfsr_ram.sv
// ----------------------------------------------------------------------------
// sfsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sfsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sfsr_queue.sv
// ----------------------------------------------------------------------------
// sfsr_queue
// Two-entry job queue between the frame parser and the result emitter.
// ----------------------------------------------------------------------------
module sfsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfsr_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sfsr_pkg::job_t head_job
);
  import sfsr_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/sfsr_front.sv
// ----------------------------------------------------------------------------
// sfsr_front
// Frame parser: takes requests and bytes, fills the payload buffer, checks
// the frame and queues one job per error or good frame.
// ----------------------------------------------------------------------------
module sfsr_front #(
  parameter int unsigned LOG_BYTES = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic [7:0]              rx_byte,
  input  logic                    cfg_we,
  input  logic signed [7:0]       cfg_wdata,
  output sfsr_pkg::buf_wr_t       buf_wr,
  output logic                    push,
  output sfsr_pkg::job_t          push_job,
  input  logic                    q_full,
  input  logic                    run_done
);
  import sfsr_pkg::*;

  localparam logic [ADDR_W-1:0] LOG_LEN    = ADDR_W'(LOG_BYTES);
  localparam logic [ADDR_W-1:0] STATUS_LEN = ADDR_W'(STATUS_BYTES);

  phase_t            phase, phase_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic              kind, kind_next;
  logic [7:0]        header_check, header_check_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [SUM_W-1:0]  sum_acc, sum_acc_next;
  logic signed [7:0] setpoint, setpoint_next;
  logic signed [7:0] setpoint_limit;
  logic              awaiting, awaiting_next;
  logic              check_done, check_done_next;
  logic              fail_flag, fail_flag_next;
  logic [CNT_W-1:0]  good_count, good_count_next;
  logic [CNT_W-1:0]  error_count, error_count_next;
  logic              run_busy;
  logic              accept;
  logic [ADDR_W-1:0] len;
  logic [ADDR_W-1:0] pos_inc;
  logic [7:0]        xor_full;
  logic              in_sum;

  assign in_ready = !q_full && !((phase == PH_PAY) && run_busy);
  assign accept   = in_valid && in_ready;
  assign len      = kind ? LOG_LEN : STATUS_LEN;
  assign pos_inc  = pos + ADDR_W'(1);
  assign xor_full = running_xor ^ rx_byte;
  assign in_sum   = (pos >= ADDR_W'(SUM_FIRST)) && (pos <= ADDR_W'(SUM_LAST));

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    kind_next         = kind;
    header_check_next = header_check;
    running_xor_next  = running_xor;
    sum_acc_next      = sum_acc;
    setpoint_next     = setpoint;
    awaiting_next     = awaiting;
    check_done_next   = check_done;
    fail_flag_next    = fail_flag;
    good_count_next   = good_count;
    error_count_next  = error_count;
    buf_wr            = '{we: 1'b0, addr: pos, data: rx_byte};
    push              = 1'b0;
    push_job.ev       = EV_PAYLOAD;
    push_job.kind     = 1'b0;
    push_job.len      = len;
    push_job.sum      = '0;

    if (accept) begin
      unique case (req_t'(req_type))
        REQ_BYTE: begin
          awaiting_next = 1'b0;
          unique case (phase)
            PH_SYNC: begin
              if (rx_byte == SYNC_BYTE) begin
                phase_next = PH_ID;
                pos_next   = '0;
              end
            end
            PH_ID: begin
              if (rx_byte[7:4] == ID_MARK) begin
                if (rx_byte[3:0] == ID_STATUS) begin
                  kind_next  = 1'b0;
                  phase_next = PH_HDR;
                end else if (rx_byte[3:0] == ID_LOG) begin
                  kind_next  = 1'b1;
                  phase_next = PH_HDR;
                end else begin
                  phase_next       = PH_SYNC;
                  pos_next         = '0;
                  error_count_next = error_count + CNT_W'(1);
                  push             = 1'b1;
                  push_job.ev      = EV_ID;
                end
              end
            end
            PH_HDR: begin
              header_check_next = rx_byte;
              running_xor_next  = '0;
              sum_acc_next      = '0;
              pos_next          = '0;
              phase_next        = PH_PAY;
            end
            PH_PAY: begin
              buf_wr.we        = 1'b1;
              running_xor_next = xor_full;
              pos_next         = pos_inc;
              if (in_sum) begin
                sum_acc_next = sum_acc + SUM_W'(rx_byte);
              end
              if (pos == ADDR_W'(SETPOINT_POS)) begin
                setpoint_next = rx_byte;
              end
              if (pos_inc == len) begin
                phase_next    = PH_SYNC;
                pos_next      = '0;
                push          = 1'b1;
                push_job.kind = kind;
                if (xor_full != header_check) begin
                  error_count_next = error_count + CNT_W'(1);
                  push_job.ev      = EV_CSUM;
                end else begin
                  good_count_next = good_count + CNT_W'(1);
                  if (!kind) begin
                    push_job.sum = sum_acc_next;
                    if (!check_done) begin
                      fail_flag_next  = (setpoint < setpoint_limit);
                      check_done_next = 1'b1;
                    end
                  end
                end
              end
            end
            default: phase_next = PH_SYNC;
          endcase
        end
        REQ_POLL: begin
          if (awaiting) begin
            awaiting_next    = 1'b0;
            error_count_next = error_count + CNT_W'(1);
            push             = 1'b1;
            push_job.ev      = EV_TIMEOUT;
          end
        end
        REQ_SENT: awaiting_next = 1'b1;
        default:  awaiting_next = awaiting;
      endcase
    end

    push_job.fail = fail_flag_next;
    push_job.good = good_count_next;
    push_job.errs = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC;
      pos            <= '0;
      kind           <= 1'b0;
      header_check   <= '0;
      running_xor    <= '0;
      awaiting       <= 1'b0;
      check_done     <= 1'b0;
      fail_flag      <= 1'b0;
      good_count     <= '0;
      error_count    <= '0;
      run_busy       <= 1'b0;
      setpoint_limit <= SETPOINT_RESET;
    end else begin
      phase        <= phase_next;
      pos          <= pos_next;
      kind         <= kind_next;
      header_check <= header_check_next;
      running_xor  <= running_xor_next;
      awaiting     <= awaiting_next;
      check_done   <= check_done_next;
      fail_flag    <= fail_flag_next;
      good_count   <= good_count_next;
      error_count  <= error_count_next;
      if (push && (push_job.ev == EV_PAYLOAD)) begin
        run_busy <= 1'b1;
      end else if (run_done) begin
        run_busy <= 1'b0;
      end
      if (cfg_we) begin
        setpoint_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_acc  <= sum_acc_next;
    setpoint <= setpoint_next;
  end

endmodule

### design/sfsr_back.sv
// ----------------------------------------------------------------------------
// sfsr_back
// Result emitter: pops jobs, gives one error result or walks the payload
// buffer to give a run of payload results.
// ----------------------------------------------------------------------------
module sfsr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  sfsr_pkg::job_t                head_job,
  output logic                          pop,
  output logic                          buf_re,
  output logic [sfsr_pkg::ADDR_W-1:0]   buf_raddr,
  input  logic [7:0]                    buf_rdata,
  output logic                          run_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    event_res,
  output logic                          frame_kind,
  output logic [sfsr_pkg::ADDR_W-1:0]   byte_index,
  output logic [7:0]                    byte_value,
  output logic                          last,
  output logic [sfsr_pkg::SUM_W-1:0]    current_sum,
  output logic                          config_fail,
  output logic [sfsr_pkg::CNT_W-1:0]    good_frames,
  output logic [sfsr_pkg::CNT_W-1:0]    error_total
);
  import sfsr_pkg::*;

  back_state_t       state;
  job_t              job;
  logic [ADDR_W-1:0] idx;
  logic              is_run;
  logic              run_last;

  assign is_run    = (job.ev == EV_PAYLOAD);
  assign run_last  = (idx == (job.len - ADDR_W'(1)));
  assign pop       = (state == BK_IDLE) && head_valid;
  assign buf_re    = (state == BK_READ);
  assign buf_raddr = idx;
  assign out_valid = (state == BK_SHOW);
  assign run_done  = out_valid && out_ready && is_run && run_last;

  assign event_res   = job.ev;
  assign frame_kind  = job.kind;
  assign byte_index  = is_run ? idx : '0;
  assign byte_value  = is_run ? buf_rdata : 8'd0;
  assign last        = is_run ? run_last : 1'b1;
  assign current_sum = job.sum;
  assign config_fail = job.fail;
  assign good_frames = job.good;
  assign error_total = job.errs;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (head_valid) begin
            idx   <= '0;
            state <= (head_job.ev == EV_PAYLOAD) ? BK_READ : BK_SHOW;
          end
        end
        BK_READ: state <= BK_SHOW;
        BK_SHOW: begin
          if (out_ready) begin
            if (!is_run || run_last) begin
              state <= BK_IDLE;
            end else begin
              idx   <= idx + ADDR_W'(1);
              state <= BK_READ;
            end
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed status receiver. Serial bytes and
// request markers go in over the input stream. Every output transfer is
// compared field by field against a behavioral receiver kept in the bench.
// The stimulus is a few directed cases first, then random frames, broken
// frames and request noise under three source/sink stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfsr_pkg::*;

  localparam int unsigned LOG_LEN   = 32;
  localparam int          CFG_DRAIN = 16;
  localparam int          END_DRAIN = 40;
  localparam int          STALL_MAX = 4000;

  typedef struct {
    event_t      ev;
    logic        kind;
    logic [5:0]  idx;
    logic [7:0]  val;
    logic        last;
    logic [10:0] sum;
    logic        fail;
    logic [15:0] good;
    logic [15:0] errs;
  } rx_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              cfg_we = 1'b0;
  logic signed [7:0] cfg_wdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tlast;

  int src_idle_pct = 25;
  int dst_idle_pct = 82;
  int items_sent   = 0;
  int mismatches   = 0;
  int stall_cycles = 0;

  // receiver state as seen from outside
  phase_t            rx_phase     = PH_SYNC;
  logic [5:0]        pos          = '0;
  logic              frame_is_log = 1'b0;
  logic [7:0]        hdr_sum      = '0;
  logic [7:0]        pay_xor      = '0;
  logic [7:0]        pay_buf [64];
  logic              poll_pending = 1'b0;
  logic              sp_checked   = 1'b0;
  logic              sp_fail      = 1'b0;
  logic [15:0]       good_cnt     = '0;
  logic [15:0]       err_cnt      = '0;
  logic signed [7:0] sp_limit     = SETPOINT_RESET;

  rx_result_t pending [$];
  logic [7:0] frame_body [64];

  sync_framed_status_receiver #(
    .LOG_BYTES(LOG_LEN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  function automatic rx_result_t make_result(event_t ev, logic kind, logic [5:0] idx,
                                             logic [7:0] val, logic last, logic [10:0] sum);
    rx_result_t r;
    r.ev   = ev;
    r.kind = kind;
    r.idx  = idx;
    r.val  = val;
    r.last = last;
    r.sum  = sum;
    r.fail = sp_fail;
    r.good = good_cnt;
    r.errs = err_cnt;
    return r;
  endfunction

  task automatic push_error(input event_t ev, input logic kind);
    err_cnt = err_cnt + 16'd1;
    pending.push_back(make_result(ev, kind, '0, '0, 1'b1, '0));
  endtask

  task automatic close_frame;
    int          len;
    logic [10:0] sum;
    len = frame_is_log ? LOG_LEN : STATUS_BYTES;
    sum = '0;
    if (pay_xor != hdr_sum) begin
      push_error(EV_CSUM, frame_is_log);
    end else begin
      good_cnt = good_cnt + 16'd1;
      if (!frame_is_log) begin
        for (int i = SUM_FIRST; i <= SUM_LAST; i++) sum = sum + pay_buf[i];
        if (!sp_checked) begin
          sp_fail    = ($signed(pay_buf[SETPOINT_POS]) < sp_limit);
          sp_checked = 1'b1;
        end
      end
      for (int i = 0; i < len; i++)
        pending.push_back(make_result(EV_PAYLOAD, frame_is_log, 6'(i), pay_buf[i],
                                      i == len - 1, sum));
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int len;
    len = frame_is_log ? LOG_LEN : STATUS_BYTES;
    poll_pending = 1'b0;
    case (rx_phase)
      PH_SYNC: begin
        if (b == SYNC_BYTE) begin
          rx_phase = PH_ID;
          pos      = '0;
        end
      end
      PH_ID: begin
        if (b[7:4] == ID_MARK) begin
          if (b[3:0] == ID_STATUS) begin
            frame_is_log = 1'b0;
            rx_phase     = PH_HDR;
          end else if (b[3:0] == ID_LOG) begin
            frame_is_log = 1'b1;
            rx_phase     = PH_HDR;
          end else begin
            rx_phase = PH_SYNC;
            pos      = '0;
            push_error(EV_ID, 1'b0);
          end
        end
      end
      PH_HDR: begin
        hdr_sum  = b;
        pay_xor  = '0;
        pos      = '0;
        rx_phase = PH_PAY;
      end
      default: begin
        pay_buf[pos] = b;
        pay_xor      = pay_xor ^ b;
        pos          = pos + 6'd1;
        if (pos == 6'(len)) begin
          rx_phase = PH_SYNC;
          pos      = '0;
          close_frame();
        end
      end
    endcase
  endtask

  task automatic predict_receiver_output(input req_t req, input logic [7:0] b);
    case (req)
      REQ_BYTE: parse_rx_byte(b);
      REQ_POLL: begin
        if (poll_pending) begin
          poll_pending = 1'b0;
          push_error(EV_TIMEOUT, 1'b0);
        end
      end
      REQ_SENT: poll_pending = 1'b1;
      default: ;
    endcase
  endtask

  task automatic send_item(input req_t req, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_receiver_output(req, b);
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic set_setpoint_limit(input logic signed [7:0] v);
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (CFG_DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sp_limit = v;
  endtask

  task automatic fill_random_body;
    for (int i = 0; i < 64; i++) frame_body[i] = 8'($urandom);
  endtask

  // requests may be slipped in between payload bytes without breaking the frame
  task automatic send_frame(input bit is_log, input bit corrupt, input bit mix);
    int         len;
    logic [7:0] cs;
    len = is_log ? LOG_LEN : STATUS_BYTES;
    cs  = '0;
    for (int i = 0; i < len; i++) cs = cs ^ frame_body[i];
    if (corrupt) cs = cs ^ 8'($urandom_range(1, 255));
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, {ID_MARK, is_log ? ID_LOG : ID_STATUS});
    send_item(REQ_BYTE, cs);
    for (int i = 0; i < len; i++) begin
      if (mix && $urandom_range(9) == 0)
        send_item(req_t'($urandom_range(1, 3)), 8'($urandom));
      send_item(REQ_BYTE, frame_body[i]);
    end
  endtask

  task automatic test_poll_requests;
    send_item(REQ_NONE, 8'h00);
    send_item(REQ_POLL, 8'hFF);
    send_item(REQ_SENT, 8'h00);
    send_item(REQ_POLL, 8'h00);
    send_item(REQ_SENT, 8'hFF);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_POLL, 8'h00);
    send_item(REQ_SENT, 8'h00);
    send_item(REQ_NONE, 8'hFF);
    send_item(REQ_POLL, 8'h00);
  endtask

  task automatic test_header_errors;
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, 8'h5A);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, {ID_MARK, 4'h7});
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, {ID_MARK, 4'hF});
  endtask

  // first good status frame latches the setpoint check; limit set at the boundary
  task automatic test_setpoint_check;
    logic signed [7:0] lim;
    logic signed [7:0] sp;
    set_setpoint_limit(8'sh80);
    set_setpoint_limit(8'sh7F);
    lim = 8'($urandom);
    sp  = (lim != 8'sh80 && $urandom_range(1) == 1) ? lim - 8'sd1 : lim;
    set_setpoint_limit(lim);
    fill_random_body();
    frame_body[SETPOINT_POS] = sp;
    for (int i = SUM_FIRST; i <= SUM_LAST; i++) frame_body[i] = 8'hFF;
    send_frame(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int         goal;
    int         pick;
    logic [7:0] b;
    logic [3:0] id;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        fill_random_body();
        send_frame($urandom_range(1), 1'b0, 1'b1);
      end else if (pick < 70) begin
        fill_random_body();
        send_frame($urandom_range(1), 1'b1, 1'b1);
      end else if (pick < 77) begin
        id = 4'($urandom);
        while (id == ID_STATUS || id == ID_LOG) id = 4'($urandom);
        send_item(REQ_BYTE, SYNC_BYTE);
        send_item(REQ_BYTE, {ID_MARK, id});
      end else if (pick < 84) begin
        // stray second byte; the next frame's sync is skipped and its id byte taken
        b = 8'($urandom);
        while (b[7:4] == ID_MARK) b = 8'($urandom);
        send_item(REQ_BYTE, SYNC_BYTE);
        send_item(REQ_BYTE, b);
      end else if (pick < 90) begin
        send_item(REQ_BYTE, SYNC_BYTE);
        send_item(REQ_BYTE, {ID_MARK, $urandom_range(1) == 1 ? ID_LOG : ID_STATUS});
        send_item(REQ_BYTE, 8'($urandom));
        repeat ($urandom_range(1, 10)) send_item(REQ_BYTE, 8'($urandom));
      end else if (pick < 95) begin
        send_item(REQ_SENT, 8'($urandom));
        if ($urandom_range(1) == 1) send_item(REQ_BYTE, 8'($urandom));
        send_item(REQ_POLL, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_item(req_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected transfer, expected none, actual tuser %0h tdata %0h",
                   $time, m_tuser, m_tdata);
      end else begin
        want = pending.pop_front();
        check_field("event_res",   want.ev,   m_tuser[1:0]);
        check_field("frame_kind",  want.kind, m_tuser[2]);
        check_field("byte_index",  want.idx,  m_tdata[5:0]);
        check_field("byte_value",  want.val,  m_tdata[13:6]);
        check_field("current_sum", want.sum,  m_tdata[24:14]);
        check_field("config_fail", want.fail, m_tdata[25]);
        check_field("good_frames", want.good, m_tdata[41:26]);
        check_field("error_total", want.errs, m_tdata[57:42]);
        check_field("tdata_pad",   0,         m_tdata[63:58]);
        check_field("last",        want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_poll_requests();
    test_header_errors();
    test_setpoint_check();

    set_setpoint_limit(8'sh7F);
    test_random_traffic(50);

    src_idle_pct = 82;
    dst_idle_pct = 25;
    set_setpoint_limit(8'sh80);
    test_random_traffic(50);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_setpoint_limit(8'($urandom));
    test_random_traffic(50);

    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
